// ===== sv/swoc_pkg.sv =====
// Shared types and constants for the sliding window outcome counter.
`timescale 1ns / 1ps
package swoc_pkg;

	localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
	localparam logic [31:0] DEF_BUCKET_LENGTH = 32'(24 * MS_PER_HOUR);
	localparam logic [31:0] DEF_WINDOW_LENGTH = 32'(7 * 24 * MS_PER_HOUR);

	localparam logic [1:0] MODE_SUCCESS = 2'd1;
	localparam logic [1:0] MODE_FAILURE = 2'd2;

	localparam logic REG_BUCKET_LENGTH = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RET_RD,
		ST_RET_CHK,
		ST_REC,
		ST_NEW_CHK,
		ST_SUM,
		ST_DONE
	} swoc_state_t;

endpackage

// ===== sv/sliding_window_outcome_counter_top.sv =====
// Top level of the bucketed sliding window success/failure counter.
//
// Usage: drive event_time and mode and raise start while busy is low; the
// item is taken at that edge. mode 1 records a success, mode 2 a failure,
// anything else only queries. One result beat follows per item: done is
// high for exactly one cycle with window_successes and window_failures
// valid. The receiver cannot stall; capture the beat when done is high.
// A new item may be started in the done cycle, so throughput equals latency.
// Sequence: the sequencer works through one RAM read port with registered
// read data. The retire scan reads and checks the oldest bucket until one
// stays or the ring is empty, the record step reads the newest bucket and
// then opens a new one or bumps it (only the read for a query or a record
// into an empty ring, which writes the new bucket at once), the window sum
// reads each live bucket in turn, and the result beat follows.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 bucket
// length, 1 window length) at once; write only while idle.
// Reset: arst_n clears the ring (empty) and restores 24 h bucket length and
// 7 day window. The bucket RAM itself is not cleared and needs no sweep.
`timescale 1ns / 1ps
module sliding_window_outcome_counter_top #(
	parameter int NUM_BUCKETS = 8,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] event_time,
	input  logic [1:0]  mode,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [31:0] window_successes,
	output logic [31:0] window_failures
);
	import swoc_pkg::*;

	localparam int IW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int LW = $clog2(NUM_BUCKETS + 1);
	localparam int EW = 64 + 2 * COUNT_BITS;
	localparam int SW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam logic [LW:0] NB = (LW + 1)'(NUM_BUCKETS);

	swoc_state_t state_q, state_d;

	logic [31:0]         bucket_len_q, window_len_q;
	logic [63:0]         t_q;
	logic [1:0]          mode_q;
	logic [IW-1:0]       oldest_q;
	logic [LW-1:0]       live_q;
	logic [LW-1:0]       k_q;
	logic                vld_q;
	logic [31:0]         succ_acc_q, fail_acc_q;

	logic                ram_we;
	logic [IW-1:0]       ram_waddr, ram_raddr;
	logic [EW-1:0]       ram_wdata, ram_rdata;

	logic [63:0]         rd_start;
	logic [COUNT_BITS-1:0] rd_succ, rd_fail;
	logic [63:0]         age;
	logic                retire, open_new, is_rec, sum_issue;
	logic [IW-1:0]       newest_slot, new_slot, sum_slot, oldest_inc;
	logic [LW:0]         oldest_ext, live_ext;
	logic [COUNT_BITS-1:0] new_succ, new_fail, inc_succ, inc_fail;
	logic [SW:0]         succ_sum, fail_sum;

	function automatic logic [IW-1:0] wrap(input logic [LW:0] x);
		logic [LW:0] y;
		y = (x >= NB) ? x - NB : x;
		return y[IW-1:0];
	endfunction

	swoc_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_BUCKETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_start = ram_rdata[EW-1 -: 64];
	assign rd_succ  = ram_rdata[2*COUNT_BITS-1 -: COUNT_BITS];
	assign rd_fail  = ram_rdata[COUNT_BITS-1:0];

	assign oldest_ext  = {{(LW + 1 - IW){1'b0}}, oldest_q};
	assign live_ext    = {1'b0, live_q};
	assign newest_slot = wrap(oldest_ext + live_ext - (LW + 1)'(1));
	assign new_slot    = wrap(oldest_ext + live_ext);
	assign oldest_inc  = wrap(oldest_ext + (LW + 1)'(1));
	assign sum_slot    = wrap(oldest_ext + {1'b0, k_q});
	assign sum_issue   = k_q < live_q;

	assign age      = (t_q > rd_start) ? t_q - rd_start : 64'd0;
	assign retire   = (t_q > rd_start) && (age >= {32'd0, window_len_q});
	assign open_new = age >= {32'd0, bucket_len_q};
	assign is_rec   = (mode_q == MODE_SUCCESS) || (mode_q == MODE_FAILURE);

	assign new_succ = COUNT_BITS'(mode_q == MODE_SUCCESS);
	assign new_fail = COUNT_BITS'(mode_q == MODE_FAILURE);
	assign inc_succ = (mode_q == MODE_SUCCESS && rd_succ != '1) ?
		rd_succ + COUNT_BITS'(1) : rd_succ;
	assign inc_fail = (mode_q == MODE_FAILURE && rd_fail != '1) ?
		rd_fail + COUNT_BITS'(1) : rd_fail;

	assign succ_sum = {1'b0, SW'(succ_acc_q)} + {1'b0, SW'(rd_succ)};
	assign fail_sum = {1'b0, SW'(fail_acc_q)} + {1'b0, SW'(rd_fail)};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_DONE: begin
				state_d = start ? ST_RET_RD : ST_IDLE;
			end
			ST_RET_RD: begin
				state_d = (live_q == '0) ? ST_REC : ST_RET_CHK;
			end
			ST_RET_CHK: begin
				state_d = retire ? ST_RET_RD : ST_REC;
			end
			ST_REC: begin
				state_d = (is_rec && live_q != '0) ? ST_NEW_CHK : ST_SUM;
			end
			ST_NEW_CHK: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = (!sum_issue && !vld_q) ? ST_DONE : ST_SUM;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = new_slot;
		ram_wdata = {t_q, new_succ, new_fail};
		ram_raddr = oldest_q;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_DONE: begin
				busy = 1'b0;
				done = 1'b1;
			end
			ST_RET_RD, ST_RET_CHK: begin
				ram_raddr = oldest_q;
			end
			ST_REC: begin
				ram_raddr = newest_slot;
				ram_we    = is_rec && live_q == '0;
			end
			ST_NEW_CHK: begin
				ram_we = 1'b1;
				if (!open_new) begin
					ram_waddr = newest_slot;
					ram_wdata = {rd_start, inc_succ, inc_fail};
				end
			end
			ST_SUM: begin
				ram_raddr = sum_slot;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bucket_len_q <= DEF_BUCKET_LENGTH;
			window_len_q <= DEF_WINDOW_LENGTH;
			oldest_q     <= '0;
			live_q       <= '0;
			k_q          <= '0;
			vld_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BUCKET_LENGTH: bucket_len_q <= cfg_data;
					REG_WINDOW_LENGTH: window_len_q <= cfg_data;
					default: bucket_len_q <= bucket_len_q;
				endcase
			end
			unique case (state_q)
				ST_RET_CHK: begin
					if (retire) begin
						oldest_q <= oldest_inc;
						live_q   <= live_q - LW'(1);
					end
				end
				ST_REC: begin
					k_q   <= '0;
					vld_q <= 1'b0;
					if (is_rec && live_q == '0) begin
						live_q <= LW'(1);
					end
				end
				ST_NEW_CHK: begin
					k_q   <= '0;
					vld_q <= 1'b0;
					if (open_new) begin
						if (live_q == LW'(NUM_BUCKETS)) begin
							oldest_q <= oldest_inc;
						end else begin
							live_q <= live_q + LW'(1);
						end
					end
				end
				ST_SUM: begin
					vld_q <= sum_issue;
					if (sum_issue) begin
						k_q <= k_q + LW'(1);
					end
				end
				default: begin
					vld_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE || state_q == ST_DONE) && start) begin
			t_q    <= event_time;
			mode_q <= mode;
		end
		if (state_q == ST_REC || state_q == ST_NEW_CHK) begin
			succ_acc_q <= '0;
			fail_acc_q <= '0;
		end else if (state_q == ST_SUM && vld_q) begin
			succ_acc_q <= (|succ_sum[SW:32]) ? 32'hFFFF_FFFF : succ_sum[31:0];
			fail_acc_q <= (|fail_sum[SW:32]) ? 32'hFFFF_FFFF : fail_sum[31:0];
		end
	end

	assign window_successes = succ_acc_q;
	assign window_failures  = fail_acc_q;

endmodule

// ===== sv/swoc_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module swoc_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== verif/tb_sliding_window_outcome_counter_top.sv =====
// Self-checking testbench for the sliding window outcome counter top level.
`timescale 1ns / 1ps
module tb_sliding_window_outcome_counter_top;
	import swoc_pkg::*;

	localparam int RING_DEPTH = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] MODE_QUERY = 2'd0;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [63:0] DAY = 64'(DEF_BUCKET_LENGTH);
	localparam logic [63:0] WEEK = 64'(DEF_WINDOW_LENGTH);
	localparam logic [63:0] T_MAX = '1;
	localparam logic [31:0] LEN_MAX = '1;

	typedef struct packed {
		logic [31:0] succ;
		logic [31:0] fail;
	} window_totals_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [63:0] value;
		logic [1:0] mode;
		logic reg_sel;
		logic typed;
		window_totals_t totals;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [63:0] event_time = '0;
	logic [1:0] mode = MODE_QUERY;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_BUCKET_LENGTH;
	logic [31:0] cfg_data = '0;
	logic done;
	logic [31:0] window_successes;
	logic [31:0] window_failures;

	// ring image
	logic [63:0] ring_start [RING_DEPTH];
	logic [31:0] ring_succ [RING_DEPTH];
	logic [31:0] ring_fail [RING_DEPTH];
	int ring_head = 0;
	int ring_fill = 0;
	logic [31:0] bucket_len = DEF_BUCKET_LENGTH;
	logic [31:0] window_len = DEF_WINDOW_LENGTH;

	window_totals_t pending_totals [$];
	row_t directed_rows [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;

	sliding_window_outcome_counter_top #(
		.NUM_BUCKETS(RING_DEPTH),
		.COUNT_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.event_time(event_time),
		.mode(mode),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.window_successes(window_successes),
		.window_failures(window_failures)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] age_of(input logic [63:0] t, input logic [63:0] s);
		return (t > s) ? t - s : 64'd0;
	endfunction

	function automatic window_totals_t advance_ring(input logic [63:0] t, input logic [1:0] m);
		int idx;
		logic open;
		logic [63:0] ssum;
		logic [63:0] fsum;
		window_totals_t tot;
		while (ring_fill > 0 && t > ring_start[ring_head]
				&& age_of(t, ring_start[ring_head]) >= 64'(window_len)) begin
			ring_head = (ring_head + 1) % RING_DEPTH;
			ring_fill--;
		end
		if (m == MODE_SUCCESS || m == MODE_FAILURE) begin
			open = (ring_fill == 0);
			if (!open) begin
				idx = (ring_head + ring_fill - 1) % RING_DEPTH;
				open = age_of(t, ring_start[idx]) >= 64'(bucket_len);
			end
			if (open) begin
				if (ring_fill >= RING_DEPTH) begin
					ring_head = (ring_head + 1) % RING_DEPTH;
					ring_fill = RING_DEPTH - 1;
				end
				idx = (ring_head + ring_fill) % RING_DEPTH;
				ring_start[idx] = t;
				ring_succ[idx] = '0;
				ring_fail[idx] = '0;
				ring_fill++;
			end
			idx = (ring_head + ring_fill - 1) % RING_DEPTH;
			if (m == MODE_SUCCESS) begin
				if (ring_succ[idx] != '1)
					ring_succ[idx]++;
			end else if (ring_fail[idx] != '1) begin
				ring_fail[idx]++;
			end
		end
		ssum = '0;
		fsum = '0;
		for (int k = 0; k < ring_fill; k++) begin
			idx = (ring_head + k) % RING_DEPTH;
			ssum += 64'(ring_succ[idx]);
			fsum += 64'(ring_fail[idx]);
			if (ssum > 64'hFFFF_FFFF)
				ssum = 64'hFFFF_FFFF;
			if (fsum > 64'hFFFF_FFFF)
				fsum = 64'hFFFF_FFFF;
		end
		tot.succ = ssum[31:0];
		tot.fail = fsum[31:0];
		return tot;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// directed table builders
	task automatic add_item(input logic [63:0] t, input logic [1:0] m);
		row_t r;
		r.kind = ROW_ITEM;
		r.value = t;
		r.mode = m;
		r.reg_sel = REG_BUCKET_LENGTH;
		r.typed = 1'b0;
		r.totals = '0;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic add_check(input logic [63:0] t, input logic [1:0] m,
			input logic [31:0] s, input logic [31:0] f);
		row_t r;
		r.kind = ROW_ITEM;
		r.value = t;
		r.mode = m;
		r.reg_sel = REG_BUCKET_LENGTH;
		r.typed = 1'b1;
		r.totals.succ = s;
		r.totals.fail = f;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic add_reg(input logic sel, input logic [31:0] val);
		row_t r;
		r.kind = ROW_REG;
		r.value = 64'(val);
		r.mode = MODE_QUERY;
		r.reg_sel = sel;
		r.typed = 1'b0;
		r.totals = '0;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic drive_beat(input logic [63:0] t, input logic [1:0] m,
			input logic typed, input window_totals_t typed_totals);
		window_totals_t predicted;
		logic taken;
		taken = 1'b0;
		event_time <= t;
		mode <= m;
		while (!taken) begin
			if (idle_on && $urandom_range(99) < 11) begin
				start <= 1'b0;
				@(posedge clk);
			end else begin
				start <= 1'b1;
				@(posedge clk);
				taken = !busy;
			end
		end
		predicted = advance_ring(t, m);
		pending_totals.insert(pending_totals.size(), typed ? typed_totals : predicted);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		if (sel == REG_BUCKET_LENGTH)
			bucket_len = val;
		else
			window_len = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		window_totals_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_sliding_window_outcome_counter_top NOT OK");
			$finish;
		end
		if (arst_n && done) begin
			if (pending_totals.size() == 0) begin
				note_mismatch($sformatf("unexpected beat %0d/%0d",
					window_successes, window_failures));
			end else begin
				want = pending_totals.pop_front();
				if (window_successes !== want.succ)
					note_mismatch($sformatf("successes got %0d want %0d",
						window_successes, want.succ));
				if (window_failures !== want.fail)
					note_mismatch($sformatf("failures got %0d want %0d",
						window_failures, want.fail));
			end
		end
	end

	initial begin
		logic [31:0] phase_bucket [10];
		logic [31:0] phase_window [10];
		logic [31:0] step_max;
		logic [63:0] cursor;
		logic [63:0] t;
		logic [1:0] m;
		int r;
		int mr;

		add_check(64'd0, MODE_QUERY, 32'd0, 32'd0);
		add_check(64'd0, MODE_SUCCESS, 32'd1, 32'd0);
		add_check(64'd0, MODE_FAILURE, 32'd1, 32'd1);
		add_check(64'd0, MODE_SPARE, 32'd1, 32'd1);
		add_check(DAY - 64'd1, MODE_SUCCESS, 32'd2, 32'd1);
		add_check(DAY, MODE_SUCCESS, 32'd3, 32'd1);
		add_check(WEEK, MODE_QUERY, 32'd1, 32'd0);
		// timestamp older than newest bucket
		add_check(64'd100, MODE_FAILURE, 32'd1, 32'd1);
		// zero bucket length, ring overflow
		add_reg(REG_BUCKET_LENGTH, 32'd0);
		add_reg(REG_WINDOW_LENGTH, LEN_MAX);
		for (int i = 1; i <= 9; i++)
			add_item(WEEK + 64'(i), MODE_SUCCESS);
		add_reg(REG_WINDOW_LENGTH, 32'd0);
		add_check(WEEK + 64'd9, MODE_QUERY, 32'd1, 32'd0);
		add_reg(REG_BUCKET_LENGTH, LEN_MAX);
		add_reg(REG_WINDOW_LENGTH, LEN_MAX);
		add_check(T_MAX, MODE_QUERY, 32'd0, 32'd0);
		add_check(T_MAX, MODE_FAILURE, 32'd0, 32'd1);
		add_check(64'd0, MODE_SUCCESS, 32'd1, 32'd1);
		add_check(T_MAX, MODE_SPARE, 32'd1, 32'd1);

		phase_bucket = '{DEF_BUCKET_LENGTH, 32'd10, 32'd1, 32'd0, 32'd3,
			32'd7, 32'd1, LEN_MAX, 32'($urandom_range(1, 20)), $urandom};
		phase_window = '{DEF_WINDOW_LENGTH, 32'd50, 32'd1, 32'd25, 32'd40,
			32'd0, LEN_MAX, LEN_MAX, 32'($urandom_range(1, 200)), $urandom};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				drain();
				write_reg(directed_rows[i].reg_sel, directed_rows[i].value[31:0]);
			end else begin
				drive_beat(directed_rows[i].value, directed_rows[i].mode,
					directed_rows[i].typed, directed_rows[i].totals);
			end
		end

		for (int p = 0; p < 10; p++) begin
			drain();
			write_reg(REG_BUCKET_LENGTH, phase_bucket[p]);
			write_reg(REG_WINDOW_LENGTH, phase_window[p]);
			idle_on = (p != 4);
			step_max = (phase_bucket[p] >> 2) + 32'd2;
			cursor = {$urandom, $urandom};
			repeat (100) begin
				r = $urandom_range(99);
				if (r < 4) begin
					t = {$urandom, $urandom};
				end else if (r < 12) begin
					t = cursor - 64'($urandom_range(0, step_max));
				end else begin
					if (r < 15)
						cursor += 64'(phase_window[p]);
					cursor += 64'($urandom_range(0, step_max));
					t = cursor;
				end
				mr = $urandom_range(99);
				if (mr < 40)
					m = MODE_SUCCESS;
				else if (mr < 75)
					m = MODE_FAILURE;
				else if (mr < 94)
					m = MODE_QUERY;
				else
					m = MODE_SPARE;
				drive_beat(t, m, 1'b0, '0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_sliding_window_outcome_counter_top OK");
		else
			$display("tb_sliding_window_outcome_counter_top NOT OK");
		$finish;
	end

endmodule
